// ===== hdl/cubical_cell_boundary_macros.svh =====
// Assertion helpers used by ccb_back.
`ifndef CUBICAL_CELL_BOUNDARY_MACROS_SVH
`define CUBICAL_CELL_BOUNDARY_MACROS_SVH

// Clocked property, masked while reset is asserted.
`define CCB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define CCB_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `CCB_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

// ===== hdl/ccb_pkg.sv =====
`default_nettype none

package ccb_pkg;

  localparam int ID_W               = 44;
  localparam int DIM_W              = 3;
  localparam int NUM_AXES_W         = 3;
  localparam int SIZE_W             = 11;
  localparam int NUM_SIZE_REGS      = 4;
  localparam int APB_ADDR_W         = 5;
  localparam int APB_DATA_W         = 32;
  localparam int JOBQ_DEPTH         = 2;
  localparam int DEF_MAX_AXES       = 4;
  localparam int DEF_MAX_COORD_BITS = 10;

  localparam logic [NUM_AXES_W-1:0] NUM_AXES_RESET = 3'd2;
  localparam logic [SIZE_W-1:0]     SIZE_RESET     = 11'd1024;

  typedef enum logic [2:0] {
    REG_NUM_AXES   = 3'd0,
    REG_AXIS0_SIZE = 3'd1,
    REG_AXIS1_SIZE = 3'd2,
    REG_AXIS2_SIZE = 3'd3,
    REG_AXIS3_SIZE = 3'd4
  } ccb_reg_e;

  // Axes that have a size register behind them.
  function automatic int ccb_num_axes(int max_axes);
    return (max_axes < NUM_SIZE_REGS) ? max_axes : NUM_SIZE_REGS;
  endfunction

  // Bits of a field offset: sum of all field widths fits.
  function automatic int ccb_off_bits(int na, int mcb);
    return $clog2(na * (mcb + 1) + 1);
  endfunction

  // Job word: id, current coords, next coords, extent mask, dimension.
  function automatic int ccb_job_bits(int na, int mcb);
    return ID_W + 2 * na * mcb + na + DIM_W;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/ccb_cfg.sv =====
`default_nettype none

module ccb_cfg #(
  parameter int  MAX_AXES       = ccb_pkg::DEF_MAX_AXES,
  parameter int  MAX_COORD_BITS = ccb_pkg::DEF_MAX_COORD_BITS,
  localparam int NA             = ccb_pkg::ccb_num_axes(MAX_AXES),
  localparam int FW             = MAX_COORD_BITS + 1,
  localparam int OffW           = ccb_pkg::ccb_off_bits(NA, MAX_COORD_BITS)
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ccb_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [ccb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [ccb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  output logic      [OffW-1:0]                 off_o   [NA],
  output logic      [FW-1:0]                   size_o  [NA],
  output logic      [ccb_pkg::ID_W-1:0]        fmask_o [NA],
  output logic      [NA-1:0]                   used_o
);
  import ccb_pkg::*;

  localparam int BW   = $clog2(FW + 1);
  localparam int CmpW = (SIZE_W > FW) ? SIZE_W : FW;
  localparam int AuW  = NUM_AXES_W + 1;

  logic [NUM_AXES_W-1:0] num_axes_q;
  logic [SIZE_W-1:0]     size_q [NUM_SIZE_REGS];
  ccb_reg_e              idx;
  logic                  wr_en;

  logic [FW-1:0]   sz_c    [NA];
  logic [BW-1:0]   bits_c  [NA];
  logic [OffW-1:0] off_c   [NA];
  logic [ID_W-1:0] fmask_c [NA];
  logic [NA-1:0]   used_c;

  assign pready = 1'b1;
  assign idx    = ccb_reg_e'(paddr[APB_ADDR_W-1:2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_axes_q <= NUM_AXES_RESET;
      for (int n = 0; n < NUM_SIZE_REGS; n++) begin
        size_q[n] <= SIZE_RESET;
      end
    end else if (wr_en) begin
      unique case (idx)
        REG_NUM_AXES:   num_axes_q <= pwdata[NUM_AXES_W-1:0];
        REG_AXIS0_SIZE: size_q[0]  <= pwdata[SIZE_W-1:0];
        REG_AXIS1_SIZE: size_q[1]  <= pwdata[SIZE_W-1:0];
        REG_AXIS2_SIZE: size_q[2]  <= pwdata[SIZE_W-1:0];
        REG_AXIS3_SIZE: size_q[3]  <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NUM_AXES:   prdata = APB_DATA_W'(num_axes_q);
      REG_AXIS0_SIZE: prdata = APB_DATA_W'(size_q[0]);
      REG_AXIS1_SIZE: prdata = APB_DATA_W'(size_q[1]);
      REG_AXIS2_SIZE: prdata = APB_DATA_W'(size_q[2]);
      REG_AXIS3_SIZE: prdata = APB_DATA_W'(size_q[3]);
      default:        prdata = '0;
    endcase
  end

  // Field geometry: clamp size, width = ceil(log2(size)) + 1, offsets add up.
  always_comb begin
    logic [CmpW-1:0] szw;
    logic [CmpW-1:0] topw;
    logic [FW-1:0]   sm1;
    logic [BW-1:0]   k;
    logic [AuW-1:0]  au;
    au = AuW'(num_axes_q);
    if (au == '0) begin
      au = AuW'(1);
    end
    if (au > AuW'(NA)) begin
      au = AuW'(NA);
    end
    for (int n = 0; n < NA; n++) begin
      szw  = CmpW'(size_q[n]);
      topw = CmpW'(1) << MAX_COORD_BITS;
      if (szw == '0) begin
        szw = CmpW'(1);
      end else if (szw > topw) begin
        szw = topw;
      end
      sz_c[n] = FW'(szw);
      sm1     = sz_c[n] - FW'(1);
      k       = '0;
      for (int i = 0; i < FW; i++) begin
        if (sm1[i]) begin
          k = BW'(i + 1);
        end
      end
      bits_c[n] = k + BW'(1);
    end
    off_c[0] = '0;
    for (int n = 1; n < NA; n++) begin
      off_c[n] = off_c[n-1] + OffW'(bits_c[n-1]);
    end
    for (int n = 0; n < NA; n++) begin
      fmask_c[n] = ((ID_W'(1) << bits_c[n]) - ID_W'(1)) << off_c[n];
      used_c[n]  = (AuW'(n) < au) && (int'(off_c[n]) < ID_W);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int n = 0; n < NA; n++) begin
      off_o[n]   <= off_c[n];
      size_o[n]  <= sz_c[n];
      fmask_o[n] <= fmask_c[n];
    end
    used_o <= used_c;
  end

endmodule

`default_nettype wire

// ===== hdl/ccb_front.sv =====
`default_nettype none

module ccb_front #(
  parameter int  MAX_AXES       = ccb_pkg::DEF_MAX_AXES,
  parameter int  MAX_COORD_BITS = ccb_pkg::DEF_MAX_COORD_BITS,
  localparam int NA             = ccb_pkg::ccb_num_axes(MAX_AXES),
  localparam int CW             = MAX_COORD_BITS,
  localparam int FW             = MAX_COORD_BITS + 1,
  localparam int OffW           = ccb_pkg::ccb_off_bits(NA, MAX_COORD_BITS),
  localparam int JobW           = ccb_pkg::ccb_job_bits(NA, MAX_COORD_BITS)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      push,
  output logic                           full,
  input  wire logic [ccb_pkg::ID_W-1:0]  cell_id_i,
  input  wire logic [OffW-1:0]           off_i   [NA],
  input  wire logic [FW-1:0]             size_i  [NA],
  input  wire logic [ccb_pkg::ID_W-1:0]  fmask_i [NA],
  input  wire logic [NA-1:0]             used_i,
  output logic                           jq_push_o,
  input  wire logic                      jq_full_i,
  output logic      [JobW-1:0]           jq_data_o
);
  import ccb_pkg::*;

  logic            in_valid_q;
  logic            in_valid_d;
  logic [ID_W-1:0] in_id_q;

  logic [NA-1:0]    ext;
  logic [NA*CW-1:0] crd_flat;
  logic [NA*CW-1:0] nxt_flat;
  logic [DIM_W-1:0] dim;
  logic             consume;
  logic             accept;

  // Pull each field apart and work out its wrapped successor.
  always_comb begin
    logic [FW-1:0] slice;
    logic [FW-1:0] nxt;
    for (int n = 0; n < NA; n++) begin
      slice  = FW'((in_id_q & fmask_i[n]) >> off_i[n]);
      ext[n] = used_i[n] && slice[0];
      nxt    = FW'(slice[FW-1:1]) + FW'(1);
      if (nxt >= size_i[n]) begin
        nxt = nxt - size_i[n];
      end
      crd_flat[n*CW +: CW] = slice[FW-1:1];
      nxt_flat[n*CW +: CW] = nxt[CW-1:0];
    end
    dim = DIM_W'($countones(ext));
  end

  // Vertices have no facets: drop them here.
  assign consume    = in_valid_q && (!(|ext) || !jq_full_i);
  assign jq_push_o  = in_valid_q && (|ext) && !jq_full_i;
  assign jq_data_o  = {dim, ext, nxt_flat, crd_flat, in_id_q};
  assign full       = in_valid_q && jq_full_i;
  assign accept     = push && !full;

  always_comb begin
    in_valid_d = in_valid_q;
    if (consume) begin
      in_valid_d = 1'b0;
    end
    if (accept) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_id_q <= cell_id_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ccb_jobq.sv =====
`default_nettype none

module ccb_jobq #(
  parameter int  WIDTH = 8,
  parameter int  DEPTH = ccb_pkg::JOBQ_DEPTH,
  localparam int PtrW  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CntW  = $clog2(DEPTH + 1)
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PtrW-1:0]  wptr_q;
  logic [PtrW-1:0]  rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push;
  logic             do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= (wptr_q == PtrW'(DEPTH - 1)) ? '0 : wptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= (rptr_q == PtrW'(DEPTH - 1)) ? '0 : rptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/ccb_back.sv =====
`default_nettype none

`include "cubical_cell_boundary_macros.svh"

module ccb_back #(
  parameter int  MAX_AXES       = ccb_pkg::DEF_MAX_AXES,
  parameter int  MAX_COORD_BITS = ccb_pkg::DEF_MAX_COORD_BITS,
  localparam int NA             = ccb_pkg::ccb_num_axes(MAX_AXES),
  localparam int CW             = MAX_COORD_BITS,
  localparam int OffW           = ccb_pkg::ccb_off_bits(NA, MAX_COORD_BITS),
  localparam int JobW           = ccb_pkg::ccb_job_bits(NA, MAX_COORD_BITS)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [OffW-1:0]            off_i   [NA],
  input  wire logic [ccb_pkg::ID_W-1:0]   fmask_i [NA],
  input  wire logic                       jq_empty_i,
  input  wire logic [JobW-1:0]            jq_data_i,
  output logic                            jq_pop_o,
  output logic                            empty,
  input  wire logic                       pop,
  output logic      [ccb_pkg::ID_W-1:0]   facet_id_o,
  output logic                            negative_sign_o,
  output logic      [ccb_pkg::DIM_W-1:0]  cell_dimension_o,
  output logic                            last_facet_o
);
  import ccb_pkg::*;

  localparam int SelW   = (NA > 1) ? $clog2(NA) : 1;
  localparam int CrdLo  = ID_W;
  localparam int NxtLo  = ID_W + NA * CW;
  localparam int MaskLo = ID_W + 2 * NA * CW;
  localparam int DimLo  = MaskLo + NA;

  // Job being walked.
  logic             cur_valid_q;
  logic [NA-1:0]    mask_q;
  logic             phase_q;
  logic [1:0]       cnt_q;
  logic [ID_W-1:0]  id_q;
  logic [NA*CW-1:0] crd_q;
  logic [NA*CW-1:0] nxt_q;
  logic [DIM_W-1:0] dim_q;

  // Result register.
  logic             out_valid_q;
  logic [ID_W-1:0]  facet_q;
  logic             neg_q;
  logic [DIM_W-1:0] odim_q;
  logic             last_q;

  logic [SelW-1:0]  sel;
  logic [NA-1:0]    rest;
  logic             is_last;
  logic [CW-1:0]    coord;
  logic [OffW:0]    shamt;
  logic [ID_W-1:0]  facet;
  logic             neg;
  logic             advance;
  logic             load;

  // Lowest extended axis still pending.
  always_comb begin
    sel = '0;
    for (int n = NA - 1; n >= 0; n--) begin
      if (mask_q[n]) begin
        sel = SelW'(n);
      end
    end
  end

  assign rest    = mask_q & ~(NA'(1) << sel);
  assign is_last = phase_q && (rest == '0);
  assign coord   = phase_q ? crd_q[int'(sel)*CW +: CW] : nxt_q[int'(sel)*CW +: CW];
  assign shamt   = (OffW+1)'(off_i[sel]) + (OffW+1)'(1);
  assign facet   = (id_q & ~fmask_i[sel]) | (ID_W'(coord) << shamt);
  assign neg     = (cnt_q == 2'd1) || (cnt_q == 2'd2);

  assign advance  = cur_valid_q && (!out_valid_q || pop);
  assign load     = !jq_empty_i && (!cur_valid_q || (advance && is_last));
  assign jq_pop_o = load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      mask_q      <= '0;
      phase_q     <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        cur_valid_q <= 1'b1;
        mask_q      <= jq_data_i[MaskLo +: NA];
        phase_q     <= 1'b0;
        cnt_q       <= '0;
      end else if (advance) begin
        if (is_last) begin
          cur_valid_q <= 1'b0;
        end
        if (phase_q) begin
          mask_q <= rest;
        end
        phase_q <= !phase_q;
        cnt_q   <= cnt_q + 2'd1;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      id_q  <= jq_data_i[ID_W-1:0];
      crd_q <= jq_data_i[CrdLo +: NA*CW];
      nxt_q <= jq_data_i[NxtLo +: NA*CW];
      dim_q <= jq_data_i[DimLo +: DIM_W];
    end
    if (advance) begin
      facet_q <= facet;
      neg_q   <= neg;
      odim_q  <= dim_q;
      last_q  <= is_last;
    end
  end

  assign empty            = !out_valid_q;
  assign facet_id_o       = facet_q;
  assign negative_sign_o  = neg_q;
  assign cell_dimension_o = odim_q;
  assign last_facet_o     = last_q;

  `CCB_ASSERT(a_job_has_axis, clk_i, rst_ni, cur_valid_q |-> (mask_q != '0), "active job has no axis left")
  `CCB_ASSERT(a_phase_tracks_count, clk_i, rst_ni, cur_valid_q |-> (cnt_q[0] == phase_q), "facet count out of step with axis phase")
  `CCB_ASSERT(a_last_sign, clk_i, rst_ni, (out_valid_q && last_q) |-> (negative_sign_o == cell_dimension_o[0]), "sign of final facet does not match dimension")
  `CCB_ASSERT_NEVER(a_cell_cut_short, clk_i, rst_ni, out_valid_q && !last_q && !cur_valid_q, "cell ended before its last facet")

endmodule

`default_nettype wire

// ===== hdl/cubical_cell_boundary.sv =====
// Boundary of a cubical cell: one input beat per cell, one output beat per facet.
// Input queue side: present cell_id_i with push; the beat is taken when full is low.
// Output queue side: the oldest facet sits on the result ports while empty is low;
// pop takes it. Each extended axis, lowest first, yields two facets (coordinate+1
// with wrap, then the coordinate itself), extent bit cleared; signs run +,-,-,+.
// cell_dimension_o repeats on every facet of the cell and last_facet_o marks the
// final one. A cell with no extended axis produces no output.
// The output register gives one facet per cycle while pop is high; a cell of
// dimension d (up to 4) yields 2*d facets and a vertex is dropped at the input.
// A two-entry job queue between classification and the facet walker lets input
// keep flowing while facets drain. When pop is held low the walker holds and
// the job queue fills, after which full rises.
// Configuration is through the APB port (registers at 4*i); field geometry is
// computed from the register file and registered again in ccb_cfg. Reset
// empties all stages and loads two axes of size 1024.
`default_nettype none

module cubical_cell_boundary #(
  parameter int  MAX_AXES       = ccb_pkg::DEF_MAX_AXES,
  parameter int  MAX_COORD_BITS = ccb_pkg::DEF_MAX_COORD_BITS
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [ccb_pkg::APB_ADDR_W-1:0]  paddr,
  input  wire logic [ccb_pkg::APB_DATA_W-1:0]  pwdata,
  output logic      [ccb_pkg::APB_DATA_W-1:0]  prdata,
  output logic                                 pready,
  input  wire logic                            push,
  output logic                                 full,
  input  wire logic [ccb_pkg::ID_W-1:0]        cell_id_i,
  output logic                                 empty,
  input  wire logic                            pop,
  output logic      [ccb_pkg::ID_W-1:0]        facet_id_o,
  output logic                                 negative_sign_o,
  output logic      [ccb_pkg::DIM_W-1:0]       cell_dimension_o,
  output logic                                 last_facet_o
);
  import ccb_pkg::*;

  localparam int NA   = ccb_num_axes(MAX_AXES);
  localparam int FW   = MAX_COORD_BITS + 1;
  localparam int OffW = ccb_off_bits(NA, MAX_COORD_BITS);
  localparam int JobW = ccb_job_bits(NA, MAX_COORD_BITS);

  logic [OffW-1:0] off   [NA];
  logic [FW-1:0]   size  [NA];
  logic [ID_W-1:0] fmask [NA];
  logic [NA-1:0]   used;

  logic            jq_push;
  logic            jq_full;
  logic [JobW-1:0] jq_wdata;
  logic            jq_pop;
  logic [JobW-1:0] jq_rdata;
  logic            jq_empty;

  ccb_cfg #(
    .MAX_AXES       (MAX_AXES),
    .MAX_COORD_BITS (MAX_COORD_BITS)
  ) u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .off_o   (off),
    .size_o  (size),
    .fmask_o (fmask),
    .used_o  (used)
  );

  ccb_front #(
    .MAX_AXES       (MAX_AXES),
    .MAX_COORD_BITS (MAX_COORD_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push      (push),
    .full      (full),
    .cell_id_i (cell_id_i),
    .off_i     (off),
    .size_i    (size),
    .fmask_i   (fmask),
    .used_i    (used),
    .jq_push_o (jq_push),
    .jq_full_i (jq_full),
    .jq_data_o (jq_wdata)
  );

  ccb_jobq #(
    .WIDTH (JobW),
    .DEPTH (JOBQ_DEPTH)
  ) u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (jq_push),
    .data_i  (jq_wdata),
    .full_o  (jq_full),
    .pop_i   (jq_pop),
    .data_o  (jq_rdata),
    .empty_o (jq_empty)
  );

  ccb_back #(
    .MAX_AXES       (MAX_AXES),
    .MAX_COORD_BITS (MAX_COORD_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .off_i            (off),
    .fmask_i          (fmask),
    .jq_empty_i       (jq_empty),
    .jq_data_i        (jq_rdata),
    .jq_pop_o         (jq_pop),
    .empty            (empty),
    .pop              (pop),
    .facet_id_o       (facet_id_o),
    .negative_sign_o  (negative_sign_o),
    .cell_dimension_o (cell_dimension_o),
    .last_facet_o     (last_facet_o)
  );

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ccb_pkg::*;

  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 16;
  localparam int MAX_FACETS   = 2 * DEF_MAX_AXES;

  // Addresses past the register map; writes there must be dropped.
  localparam logic [2:0] REG_SPARE_5 = 3'd5;
  localparam logic [2:0] REG_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [ID_W-1:0]  facet;
    logic             neg;
    logic [DIM_W-1:0] dim;
    logic             last;
  } facet_t;

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  psel      = 1'b0;
  logic                  penable   = 1'b0;
  logic                  pwrite    = 1'b0;
  logic [APB_ADDR_W-1:0] paddr     = '0;
  logic [APB_DATA_W-1:0] pwdata    = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  push      = 1'b0;
  logic                  full;
  logic [ID_W-1:0]       cell_id_i = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  logic [ID_W-1:0]       facet_id_o;
  logic                  negative_sign_o;
  logic [DIM_W-1:0]      cell_dimension_o;
  logic                  last_facet_o;

  // Shadow copy of the register file.
  logic [NUM_AXES_W-1:0] cfg_axes;
  logic [SIZE_W-1:0]     cfg_size [NUM_SIZE_REGS];

  logic [ID_W-1:0] cell_q [$];
  facet_t          facet_q [$];

  bit offer_live = 1'b0;
  int in_gap     = 0;
  int in_calm    = 0;
  int out_stall  = 0;
  int out_calm   = 0;
  int idle_count = 0;
  int errors     = 0;

  cubical_cell_boundary dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .push             (push),
    .full             (full),
    .cell_id_i        (cell_id_i),
    .empty            (empty),
    .pop              (pop),
    .facet_id_o       (facet_id_o),
    .negative_sign_o  (negative_sign_o),
    .cell_dimension_o (cell_dimension_o),
    .last_facet_o     (last_facet_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic int eff_axes();
    int a;
    a = int'(cfg_axes);
    if (a < 1) a = 1;
    if (a > DEF_MAX_AXES) a = DEF_MAX_AXES;
    return a;
  endfunction

  function automatic int eff_size(int n);
    int s;
    s = int'(cfg_size[n]);
    if (s < 1) s = 1;
    if (s > (1 << DEF_MAX_COORD_BITS)) s = 1 << DEF_MAX_COORD_BITS;
    return s;
  endfunction

  // Coordinate bits needed for the size, plus the extent bit.
  function automatic int field_width(int sz);
    int k;
    k = 0;
    while (k < DEF_MAX_COORD_BITS && (1 << k) < sz) k++;
    return k + 1;
  endfunction

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  // Append one cell to the pending input list.
  function automatic void add_cell(logic [ID_W-1:0] cid);
    cell_q.insert(cell_q.size(), cid);
  endfunction

  function automatic void predict_facets(logic [ID_W-1:0] cid);
    logic [63:0] id, fmask, slice, coord, nxt, keep;
    logic [63:0] list [MAX_FACETS];
    int          sz, bits, bottom, cnt;
    facet_t      f;
    id     = 64'(cid);
    bottom = 0;
    cnt    = 0;
    for (int n = 0; n < eff_axes(); n++) begin
      sz   = eff_size(n);
      bits = field_width(sz);
      if (bottom < ID_W) begin
        fmask = ((64'd1 << bits) - 64'd1) << bottom;
        slice = (id & fmask) >> bottom;
        if (slice[0]) begin
          coord = slice >> 1;
          nxt   = coord + 64'd1;
          if (nxt >= 64'(sz)) nxt = nxt - 64'(sz);
          keep  = id & ~fmask;
          list[cnt]     = keep | (nxt << (bottom + 1));
          list[cnt + 1] = keep | (coord << (bottom + 1));
          cnt += 2;
        end
      end
      bottom += bits;
    end
    for (int i = 0; i < cnt; i++) begin
      f.facet = list[i][ID_W-1:0];
      f.neg   = (i % 4 == 1) || (i % 4 == 2);
      f.dim   = DIM_W'(cnt / 2);
      f.last  = (i == cnt - 1);
      facet_q.insert(facet_q.size(), f);
    end
  endfunction

  // Mostly well-formed cells for the current geometry, some raw noise.
  function automatic logic [ID_W-1:0] make_cell();
    logic [63:0] id, coord, fld;
    int          sz, bits, bottom;
    id = {$urandom, $urandom};
    if ($urandom_range(0, 9) == 0) return id[ID_W-1:0];
    bottom = 0;
    for (int n = 0; n < eff_axes(); n++) begin
      sz   = eff_size(n);
      bits = field_width(sz);
      if ($urandom_range(0, 4) == 0) coord = 64'($urandom_range(0, (1 << (bits - 1)) - 1));
      else coord = 64'($urandom_range(0, sz - 1));
      fld = (coord << 1) | 64'($urandom_range(0, 99) < 65);
      id  = (id & ~(((64'd1 << bits) - 64'd1) << bottom)) | (fld << bottom);
      bottom += bits;
    end
    return id[ID_W-1:0];
  endfunction

  function automatic int draw_gap(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) begin
      calm = $urandom_range(10, 30);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] pick_size();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8);
      1: return (1 << $urandom_range(0, 10)) + $urandom_range(0, 2) - 1;
      2: return $urandom;
      default: return $urandom_range(0, 2047);
    endcase
  endfunction

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (idx == REG_NUM_AXES) cfg_axes = val[NUM_AXES_W-1:0];
    else if (idx >= REG_AXIS0_SIZE && idx <= REG_AXIS3_SIZE)
      cfg_size[idx - REG_AXIS0_SIZE] = val[SIZE_W-1:0];
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Queue random cells, then hold until every facet is back and the pipe is quiet.
  task automatic run_cells(int n_rand);
    for (int i = 0; i < n_rand; i++) add_cell(make_cell());
    do @(negedge clk_i); while (cell_q.size() > 0 || offer_live || facet_q.size() > 0);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Input side: predict on each accepted beat, hold the offer until taken.
  always @(posedge clk_i) begin
    if (rst_ni && push && !full) begin
      predict_facets(cell_id_i);
      offer_live = 1'b0;
      in_gap     = draw_gap(in_calm);
    end
  end

  always @(negedge clk_i) begin
    if (!offer_live) begin
      if (in_gap > 0) begin
        in_gap--;
        push <= 1'b0;
      end else if (cell_q.size() > 0) begin
        cell_id_i  <= cell_q.pop_front();
        push       <= 1'b1;
        offer_live = 1'b1;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Output side: check each popped beat against the oldest expected facet.
  always @(posedge clk_i) begin : facet_check
    facet_t want, got;
    if (rst_ni && pop && !empty) begin
      got = '{facet_id_o, negative_sign_o, cell_dimension_o, last_facet_o};
      if (facet_q.size() == 0) begin
        flag_error($sformatf("unexpected facet id=%h sign=%b dim=%0d last=%b",
                             got.facet, got.neg, got.dim, got.last));
      end else begin
        want = facet_q.pop_front();
        if (got !== want)
          flag_error($sformatf({"facet mismatch: expected id=%h sign=%b dim=%0d last=%b,",
                                " got id=%h sign=%b dim=%0d last=%b"},
                               want.facet, want.neg, want.dim, want.last,
                               got.facet, got.neg, got.dim, got.last));
      end
      out_stall = draw_gap(out_calm);
    end
  end

  always @(negedge clk_i) begin
    if (out_stall > 0) begin
      out_stall--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (push && !full) || (pop && !empty)) idle_count = 0;
    else idle_count++;
    if (idle_count >= STALL_LIMIT) begin
      $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
      $display("tb_top NOT OK");
      $finish;
    end
  end

  initial begin
    cfg_axes = NUM_AXES_RESET;
    foreach (cfg_size[i]) cfg_size[i] = SIZE_RESET;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset geometry: two axes of 1024, 11-bit fields.
    add_cell(44'h0);
    add_cell(44'hFFF_FFFF_FFFF);
    add_cell(44'h1);
    add_cell(44'h7FF);
    add_cell(44'h800);
    add_cell(44'h3F_F800);
    add_cell(44'h801);
    add_cell(44'hFFF_FFC0_0000);
    run_cells(20);

    // One axis of size one: a bare extent bit, coordinate always wraps to zero.
    reg_write(REG_NUM_AXES, 32'd1);
    reg_write(REG_AXIS0_SIZE, 32'd1);
    add_cell(44'h1);
    add_cell(44'hFFF_FFFF_FFFF);
    add_cell(44'hFFF_FFFF_FFFE);
    run_cells(15);

    // Full width: four 11-bit fields cover all 44 bits.
    reg_write(REG_NUM_AXES, 32'd4);
    reg_write(REG_AXIS0_SIZE, 32'd1024);
    reg_write(REG_AXIS1_SIZE, 32'd1024);
    reg_write(REG_AXIS2_SIZE, 32'd1024);
    reg_write(REG_AXIS3_SIZE, 32'd1024);
    add_cell(44'hFFF_FFFF_FFFF);
    add_cell(44'h002_0040_0801);
    add_cell(44'hFFE_0000_0000);
    add_cell(44'h555_5555_5555);
    run_cells(30);

    // Zero axis count and zero size clamp to one; spare addresses are dropped.
    reg_write(REG_NUM_AXES, 32'd0);
    reg_write(REG_AXIS0_SIZE, 32'hFFFF_F800);
    reg_write(REG_SPARE_5, 32'hFFFF_FFFF);
    reg_write(REG_SPARE_7, 32'h0000_0003);
    add_cell(44'h3);
    add_cell(44'h0);
    run_cells(15);

    // Oversized count and size clamp; odd sizes leave coordinates past the wrap point.
    reg_write(REG_NUM_AXES, 32'd7);
    reg_write(REG_AXIS0_SIZE, 32'd2047);
    reg_write(REG_AXIS1_SIZE, 32'd3);
    reg_write(REG_AXIS2_SIZE, 32'd5);
    reg_write(REG_AXIS3_SIZE, 32'd1000);
    add_cell(44'h3800);
    add_cell(44'h3_C000);
    add_cell(44'h2800);
    add_cell(44'hFFF_FFFF_FFFF);
    run_cells(30);

    repeat (4) begin
      reg_write(REG_NUM_AXES, $urandom);
      reg_write(REG_AXIS0_SIZE, pick_size());
      reg_write(REG_AXIS1_SIZE, pick_size());
      reg_write(REG_AXIS2_SIZE, pick_size());
      reg_write(REG_AXIS3_SIZE, pick_size());
      run_cells(20);
    end

    if (facet_q.size() > 0)
      flag_error($sformatf("%0d expected facets never arrived", facet_q.size()));
    if (errors == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
